### hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the Jacobi symbol engine.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Default datapath width
  localparam int WORD_BITS_DEF = 64;

  // Width of the request and result fields
  localparam int FIELD_BITS  = 64;
  localparam int SYMBOL_BITS = 2;

  // Result codes, two's complement
  localparam logic [SYMBOL_BITS-1:0] SYM_ZERO = 2'b00;
  localparam logic [SYMBOL_BITS-1:0] SYM_POS  = 2'b01;
  localparam logic [SYMBOL_BITS-1:0] SYM_NEG  = 2'b11;

  // Sign flip for a removed factor of two, indexed by modulus mod 8
  localparam logic [7:0] TWO_FLIP = 8'b0010_1000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_LOOP,
    S_OUT
  } jse_state_t;

endpackage

### hw/rtl/jacobi_symbol_engine.sv
// ----------------------------------------------------------------------------
// jacobi_symbol_engine
// Jacobi symbol (numerator / |modulus|) as -1, 0 or +1, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken only when the engine is idle; the result sits in an
// output register, so the next request is taken while that result waits.
// All remainders run through one shared subtractor as a restoring bit-serial
// division. A request is taken, the numerator is reduced by one remainder
// pass, a fix-up step follows, then the loop steps (factor stripping, swap or
// the final check) run, each swap followed by one remainder pass, and the
// result is handed to the output register. A zero modulus goes straight to
// the output step.
module jacobi_symbol_engine #(
  parameter int WORD_BITS = jse_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [jse_pkg::FIELD_BITS-1:0]  in_numerator,
  input  logic signed [jse_pkg::FIELD_BITS-1:0]  in_modulus,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jse_pkg::SYMBOL_BITS-1:0] out_symbol
);
  import jse_pkg::*;

  localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  jse_state_t             state_r, state_nxt;
  logic [WORD_BITS-1:0]   a_r, a_nxt;
  logic [WORD_BITS-1:0]   b_r, b_nxt;
  logic [WORD_BITS-1:0]   rem_r, rem_nxt;
  logic [WORD_BITS-1:0]   dvd_r, dvd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   flip_r, flip_nxt;
  logic                   aneg_r, aneg_nxt;
  logic                   loop_r, loop_nxt;
  logic [SYMBOL_BITS-1:0] res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0] out_symbol_r, out_symbol_nxt;

  logic [WORD_BITS-1:0]   num_w, mod_w, num_mag, mod_mag;
  logic [WORD_BITS:0]     sub_a, sub_b, sub_y;
  logic [WORD_BITS:0]     trial;
  logic [WORD_BITS-1:0]   rem_step;
  logic [WORD_BITS-1:0]   a_half;
  logic                   a_even;
  logic                   flip_lp;

  // Take the request fields at the datapath width and form magnitudes
  assign num_w   = in_numerator[WORD_BITS-1:0];
  assign mod_w   = in_modulus[WORD_BITS-1:0];
  assign num_mag = num_w[WORD_BITS-1] ? (~num_w + 1'b1) : num_w;
  assign mod_mag = mod_w[WORD_BITS-1] ? (~mod_w + 1'b1) : mod_w;

  // Shared subtractor: division trial, or the negative-numerator fix-up
  assign trial = {rem_r, dvd_r[WORD_BITS-1]};
  always_comb begin
    if (state_r == S_FIX) begin
      sub_a = {1'b0, b_r};
      sub_b = {1'b0, a_r};
    end else begin
      sub_a = trial;
      sub_b = {1'b0, b_r};
    end
  end
  assign sub_y    = sub_a - sub_b;
  assign rem_step = sub_y[WORD_BITS] ? trial[WORD_BITS-1:0] : sub_y[WORD_BITS-1:0];

  // Loop step helpers: single factor of two and reciprocity
  assign a_even = (a_r[1:0] == 2'b10);
  assign a_half = a_even ? {1'b0, a_r[WORD_BITS-1:1]} : a_r;
  always_comb begin
    flip_lp = flip_r;
    if (a_even) begin
      flip_lp = flip_lp ^ TWO_FLIP[b_r[2:0]];
    end
    if ((a_half[1:0] & b_r[1:0]) == 2'b11) begin
      flip_lp = ~flip_lp;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    cnt_nxt        = cnt_r;
    flip_nxt       = flip_r;
    aneg_nxt       = aneg_r;
    loop_nxt       = loop_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    in_ready       = (state_r == S_IDLE);

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dvd_nxt  = num_mag;
          b_nxt    = mod_mag;
          aneg_nxt = num_w[WORD_BITS-1];
          rem_nxt  = '0;
          cnt_nxt  = CW'(WORD_BITS - 1);
          loop_nxt = 1'b0;
          flip_nxt = 1'b0;
          if (mod_mag == '0) begin
            res_nxt   = SYM_ZERO;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // Advance the restoring division by one dividend bit
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          a_nxt     = rem_step;
          state_nxt = loop_r ? S_LOOP : S_FIX;
        end
      end
      S_FIX: begin
        // Map a negative numerator into [0, modulus)
        if (a_r == '0) begin
          res_nxt   = SYM_ZERO;
          state_nxt = S_OUT;
        end else begin
          if (aneg_r) begin
            a_nxt = sub_y[WORD_BITS-1:0];
          end
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (a_r <= WORD_BITS'(1)) begin
          res_nxt   = flip_r ? SYM_NEG : SYM_POS;
          state_nxt = S_OUT;
        end else if (a_r[1:0] == 2'b00) begin
          a_nxt = {2'b00, a_r[WORD_BITS-1:2]};
        end else begin
          // Swap and reduce the old modulus by the new one
          flip_nxt  = flip_lp;
          dvd_nxt   = b_r;
          b_nxt     = a_half;
          rem_nxt   = '0;
          cnt_nxt   = CW'(WORD_BITS - 1);
          loop_nxt  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    cnt_r        <= cnt_nxt;
    flip_r       <= flip_nxt;
    aneg_r       <= aneg_nxt;
    loop_r       <= loop_nxt;
    res_r        <= res_nxt;
    out_symbol_r <= out_symbol_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;

  // Divisor of a remainder pass is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (b_r != '0))
    else $error("remainder pass with zero divisor");

  // Partial remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < b_r))
    else $error("partial remainder out of range");

  // Result register never holds the unused code while valid
  a_sym_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_symbol_r != 2'b10))
    else $error("invalid symbol code");

  // An accepted request leaves the idle state
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("request accepted but engine stayed idle");

  // Reduced numerator in the loop is below the modulus or at most one
  a_loop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP) |-> (a_r < b_r || a_r <= WORD_BITS'(1)))
    else $error("loop operand out of range");

endmodule
